// File: design/tcce_pkg.sv
// Shared constants, payload types and address helpers for the text console cursor engine.
`timescale 1ns / 1ps
package tcce_pkg;

   localparam int SCREEN_WIDTH  = 80;
   localparam int SCREEN_HEIGHT = 25;
   localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;

   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int ADDR_W = $clog2(CELL_COUNT);
   localparam int CELL_W = 16;

   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_RETURN    = 8'd13;
   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_SPACE     = 8'd32;

   localparam logic [7:0]        COLOUR_RESET = 8'd7;
   localparam logic [CELL_W-1:0] CELL_RESET   = 16'h0720;

   typedef struct packed {
      logic [1:0]       operation;
      logic [7:0]       char_code;
      logic [ROW_W-1:0] read_row;
      logic [COL_W-1:0] read_column;
   } req_type;

   typedef struct packed {
      logic [CELL_W-1:0] cell_data;
      logic [ROW_W-1:0]  cursor_row;
      logic [COL_W-1:0]  cursor_column;
      logic              scrolled;
   } rsp_type;

   // logical row plus scroll base, modulo the screen height
   function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] row,
                                                 input logic [ROW_W-1:0] base);
      logic [ROW_W:0] sum;
      sum = {1'b0, row} + {1'b0, base};
      if (sum >= (ROW_W+1)'(SCREEN_HEIGHT)) begin
         sum = sum - (ROW_W+1)'(SCREEN_HEIGHT);
      end
      return sum[ROW_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                   input logic [COL_W-1:0] col);
      return ADDR_W'(prow) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(col);
   endfunction

endpackage

// File: design/tcce_cell_store.sv
// Character cell memory: one write port, one registered read port.
`timescale 1ns / 1ps
module tcce_cell_store
   import tcce_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [CELL_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [CELL_W-1:0] rd_data
);

   logic [CELL_W-1:0] cells_mem [CELL_COUNT];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= cells_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/text_console_cursor_engine.sv
// Top level of the text console cursor engine: cursor control, scroll and clear sequencing.
`timescale 1ns / 1ps
// Usage:
//   A transaction is taken when start is high and busy is low. req_data carries
//   the operation (put character, read cell, clear), the character and the read
//   coordinates. Every transaction gives one result on rsp_data, shown for one
//   cycle with rsp_valid high; the receiver cannot stall it.
//   csr_we/csr_wdata write the attribute byte; write it only while idle.
// Latency and throughput:
//   Put without scroll, read and unused codes: result in the cycle after the
//   transaction; a new transaction can be taken every cycle.
//   Put that scrolls: rows map through a circular base, so a scroll only blanks
//   the new bottom row, with busy high, and the result follows its last write.
//   Clear sweeps every cell with busy high, then gives its result.
//   The single write port of the cell memory makes both passes write cell by cell.
// Reset:
//   Cursor homes, attribute goes to 7, and a clearing pass over all CELL_COUNT
//   (2000) cells writes grey blanks with busy high. It gives no result.
module text_console_cursor_engine
   import tcce_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  logic    csr_we,
   input  logic [7:0] csr_wdata
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_FILL   = 2'd1;
   localparam logic [1:0] ST_SCROLL = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  base_ff, base_in;
   logic [ROW_W-1:0]  blank_row_ff, blank_row_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic [CELL_W-1:0] fill_val_ff, fill_val_in;
   logic [7:0]        colour_ff;
   logic              fill_rsp_ff, fill_rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              scrolled_ff, scrolled_in;
   logic              rd_hit_ff, rd_hit_in;

   logic              accept;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [CELL_W-1:0] wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [CELL_W-1:0] rd_data;
   logic              rd_in_range;
   logic [ROW_W-1:0]  base_next;
   logic [CELL_W-1:0] blank_cell;

   assign accept      = start && !busy;
   assign busy        = (state_ff != ST_IDLE);
   assign blank_cell  = {colour_ff, CH_SPACE};
   assign base_next   = (base_ff == ROW_W'(SCREEN_HEIGHT - 1)) ? '0 : base_ff + 1'b1;
   assign rd_in_range = (req_data.read_row < ROW_W'(SCREEN_HEIGHT)) &&
                        (req_data.read_column < COL_W'(SCREEN_WIDTH));
   assign rd_addr     = cell_addr(phys_row(req_data.read_row, base_ff), req_data.read_column);

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      base_in      = base_ff;
      blank_row_in = blank_row_ff;
      cnt_in       = cnt_ff;
      fill_val_in  = fill_val_ff;
      fill_rsp_in  = fill_rsp_ff;
      rsp_valid_in = 1'b0;
      scrolled_in  = 1'b0;
      rd_hit_in    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = cell_addr(phys_row(row_ff, base_ff), col_ff);
      wr_data      = blank_cell;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               case (req_data.operation)
                  OP_PUT: begin
                     if (req_data.char_code == CH_NEWLINE) begin
                        col_in = '0;
                        if (row_ff == ROW_W'(SCREEN_HEIGHT - 1)) begin
                           rsp_valid_in = 1'b0;
                           state_in     = ST_SCROLL;
                        end else begin
                           row_in = row_ff + 1'b1;
                        end
                     end else if (req_data.char_code == CH_RETURN) begin
                        col_in = '0;
                     end else if (req_data.char_code == CH_BACKSPACE) begin
                        if (col_ff != '0) begin
                           col_in = col_ff - 1'b1;
                        end else if (row_ff != '0) begin
                           row_in = row_ff - 1'b1;
                           col_in = COL_W'(SCREEN_WIDTH - 1);
                        end
                        wr_en   = 1'b1;
                        wr_addr = cell_addr(phys_row(row_in, base_ff), col_in);
                     end else begin
                        wr_en   = 1'b1;
                        wr_data = {colour_ff, req_data.char_code};
                        if (col_ff == COL_W'(SCREEN_WIDTH - 1)) begin
                           col_in = '0;
                           if (row_ff == ROW_W'(SCREEN_HEIGHT - 1)) begin
                              rsp_valid_in = 1'b0;
                              state_in     = ST_SCROLL;
                           end else begin
                              row_in = row_ff + 1'b1;
                           end
                        end else begin
                           col_in = col_ff + 1'b1;
                        end
                     end
                     if (state_in == ST_SCROLL) begin
                        blank_row_in = base_ff;
                        base_in      = base_next;
                        fill_val_in  = blank_cell;
                        cnt_in       = '0;
                     end
                  end
                  OP_READ: begin
                     rd_hit_in = rd_in_range;
                  end
                  OP_CLEAR: begin
                     rsp_valid_in = 1'b0;
                     row_in       = '0;
                     col_in       = '0;
                     base_in      = '0;
                     cnt_in       = '0;
                     fill_val_in  = blank_cell;
                     fill_rsp_in  = 1'b1;
                     state_in     = ST_FILL;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FILL: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            wr_data = fill_val_ff;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == ADDR_W'(CELL_COUNT - 1)) begin
               state_in     = ST_IDLE;
               rsp_valid_in = fill_rsp_ff;
               fill_rsp_in  = 1'b0;
            end
         end
         ST_SCROLL: begin
            wr_en   = 1'b1;
            wr_addr = cell_addr(blank_row_ff, cnt_ff[COL_W-1:0]);
            wr_data = fill_val_ff;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == ADDR_W'(SCREEN_WIDTH - 1)) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               scrolled_in  = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         row_ff       <= '0;
         col_ff       <= '0;
         base_ff      <= '0;
         cnt_ff       <= '0;
         fill_val_ff  <= CELL_RESET;
         fill_rsp_ff  <= 1'b0;
         colour_ff    <= COLOUR_RESET;
         rsp_valid_ff <= 1'b0;
         scrolled_ff  <= 1'b0;
         rd_hit_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         base_ff      <= base_in;
         cnt_ff       <= cnt_in;
         fill_val_ff  <= fill_val_in;
         fill_rsp_ff  <= fill_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
         scrolled_ff  <= scrolled_in;
         rd_hit_ff    <= rd_hit_in;
         if (csr_we) begin
            colour_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      blank_row_ff <= blank_row_in;
   end

   tcce_cell_store u_cell_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_data.cell_data     = rd_hit_ff ? rd_data : '0;
   assign rsp_data.cursor_row    = row_ff;
   assign rsp_data.cursor_column = col_ff;
   assign rsp_data.scrolled      = scrolled_ff;

   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.cursor_row < ROW_W'(SCREEN_HEIGHT)) &&
                    (rsp_data.cursor_column < COL_W'(SCREEN_WIDTH)))
      else $error("cursor outside the screen");

   a_base_in_range: assert property (@(posedge clock) disable iff (reset)
      base_ff < ROW_W'(SCREEN_HEIGHT))
      else $error("scroll base outside the screen");

   a_scroll_on_last_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCROLL) |-> (row_ff == ROW_W'(SCREEN_HEIGHT - 1)) &&
                                  (col_ff == '0))
      else $error("scroll with cursor off the bottom row start");

   a_scroll_result_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.scrolled) |-> $past(state_ff == ST_SCROLL))
      else $error("scrolled flag without a scroll pass");

   a_read_data_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.cell_data != '0) |->
         $past(start && !busy && req_data.operation == OP_READ))
      else $error("cell data on a result that is not a read");

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the text console cursor engine, with directed and random transactions.
`timescale 1ns / 1ps
module tb_top;
   import tcce_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic       clock;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   req_type    req_data = '0;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       csr_we = 1'b0;
   logic [7:0] csr_wdata = '0;

   // shadow of the console: cell store, cursor and attribute byte
   logic [CELL_W-1:0] shadow_cells [CELL_COUNT];
   logic [ROW_W-1:0]  cur_row = '0;
   logic [COL_W-1:0]  cur_col = '0;
   logic [7:0]        shadow_colour = COLOUR_RESET;

   rsp_type expected_rsps [$];
   int      mismatch_count = 0;

   text_console_cursor_engine i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // moves the cursor down one row; at the bottom the store scrolls up instead
   function automatic logic advance_row();
      if (int'(cur_row) == SCREEN_HEIGHT - 1) begin
         for (int i = 0; i < CELL_COUNT - SCREEN_WIDTH; i++) begin
            shadow_cells[ADDR_W'(i)] = shadow_cells[ADDR_W'(i + SCREEN_WIDTH)];
         end
         for (int i = CELL_COUNT - SCREEN_WIDTH; i < CELL_COUNT; i++) begin
            shadow_cells[ADDR_W'(i)] = {shadow_colour, CH_SPACE};
         end
         return 1'b1;
      end
      cur_row++;
      return 1'b0;
   endfunction

   function automatic rsp_type console_step(input req_type t);
      rsp_type r;
      r = '0;
      case (t.operation)
         OP_PUT: begin
            if (t.char_code == CH_NEWLINE) begin
               cur_col = '0;
               r.scrolled = advance_row();
            end else if (t.char_code == CH_RETURN) begin
               cur_col = '0;
            end else if (t.char_code == CH_BACKSPACE) begin
               if (cur_col != '0) begin
                  cur_col--;
               end else if (cur_row != '0) begin
                  cur_row--;
                  cur_col = COL_W'(SCREEN_WIDTH - 1);
               end
               shadow_cells[ADDR_W'(int'(cur_row) * SCREEN_WIDTH + int'(cur_col))] =
                  {shadow_colour, CH_SPACE};
            end else begin
               shadow_cells[ADDR_W'(int'(cur_row) * SCREEN_WIDTH + int'(cur_col))] =
                  {shadow_colour, t.char_code};
               if (int'(cur_col) == SCREEN_WIDTH - 1) begin
                  cur_col = '0;
                  r.scrolled = advance_row();
               end else begin
                  cur_col++;
               end
            end
         end
         OP_READ: begin
            if (int'(t.read_row) < SCREEN_HEIGHT && int'(t.read_column) < SCREEN_WIDTH) begin
               r.cell_data = shadow_cells[ADDR_W'(int'(t.read_row) * SCREEN_WIDTH +
                                                 int'(t.read_column))];
            end
         end
         OP_CLEAR: begin
            for (int i = 0; i < CELL_COUNT; i++) begin
               shadow_cells[ADDR_W'(i)] = {shadow_colour, CH_SPACE};
            end
            cur_row = '0;
            cur_col = '0;
         end
         default: ;
      endcase
      r.cursor_row    = cur_row;
      r.cursor_column = cur_col;
      return r;
   endfunction

   function automatic void check_field(input string name, input int unsigned expv,
                                       input int unsigned actv);
      if (expv != actv) begin
         $error("%s: expected %0h, got %0h", name, expv, actv);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_rsps.size() == 0) begin
            $error("result with no transaction outstanding: %h", rsp_data);
            mismatch_count++;
         end else begin
            exp_rsp = expected_rsps.pop_front();
            check_field("cell_data", 32'(exp_rsp.cell_data), 32'(rsp_data.cell_data));
            check_field("cursor_row", 32'(exp_rsp.cursor_row), 32'(rsp_data.cursor_row));
            check_field("cursor_column", 32'(exp_rsp.cursor_column),
                        32'(rsp_data.cursor_column));
            check_field("scrolled", 32'(exp_rsp.scrolled), 32'(rsp_data.scrolled));
         end
      end
   end

   // start stays high after acceptance; callers lower it when they pause
   task automatic send_txn(input req_type t);
      req_data <= t;
      start    <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      expected_rsps.push_back(console_step(t));
   endtask

   task automatic issue(input logic [1:0] op, input logic [7:0] ch,
                        input int row = 0, input int col = 0);
      req_type t;
      t.operation   = op;
      t.char_code   = ch;
      t.read_row    = ROW_W'(row);
      t.read_column = COL_W'(col);
      send_txn(t);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (expected_rsps.size() != 0 || busy !== 1'b0);
   endtask

   task automatic write_colour(input logic [7:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we        <= 1'b0;
      shadow_colour = value;
   endtask

   function automatic req_type random_txn(input bit long_lines);
      req_type t;
      int      pick;
      t.operation   = OP_PUT;
      t.char_code   = 8'($urandom);
      t.read_row    = 5'($urandom);
      t.read_column = 7'($urandom);
      pick = $urandom_range(0, 199);
      if (pick < 2) begin
         t.operation = OP_CLEAR;
      end else if (pick < 4) begin
         t.operation = OP_UNUSED;
      end else if (pick < 44) begin
         t.operation = OP_READ;
         case ($urandom_range(0, 3))
            0: begin
               t.read_row    = cur_row;
               t.read_column = COL_W'($urandom_range(0, SCREEN_WIDTH - 1));
            end
            1: begin
               t.read_row    = ROW_W'($urandom_range(0, SCREEN_HEIGHT - 1));
               t.read_column = COL_W'($urandom_range(0, SCREEN_WIDTH - 1));
            end
            2: ;
            default: begin
               t.read_row    = cur_row;
               t.read_column = (cur_col != '0) ? cur_col - 1'b1 : cur_col;
            end
         endcase
      end else if (!long_lines && pick < 64) begin
         t.char_code = CH_NEWLINE;
      end else if (!long_lines && pick < 74) begin
         t.char_code = CH_RETURN;
      end else if (pick < (long_lines ? 50 : 94)) begin
         t.char_code = CH_BACKSPACE;
      end
      return t;
   endfunction

   task automatic test_random_traffic(input int count, input bit with_idle);
      int idle_odds;
      bit long_lines;
      idle_odds  = 0;
      long_lines = 1'b0;
      for (int n = 0; n < count; n++) begin
         if (n % 64 == 0) begin
            idle_odds  = with_idle ? $urandom_range(0, 2) : 0;
            long_lines = ($urandom_range(0, 2) == 0);
         end
         if (idle_odds != 0 && $urandom_range(0, 3) < idle_odds) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         send_txn(random_txn(long_lines));
      end
   endtask

   task automatic test_reset_state();
      issue(OP_READ, 8'h00, 0, 0);
      issue(OP_READ, 8'hFF, SCREEN_HEIGHT - 1, SCREEN_WIDTH - 1);
      issue(OP_READ, 8'h00, SCREEN_HEIGHT, 0);
      issue(OP_READ, 8'h00, 0, SCREEN_WIDTH);
      issue(OP_READ, 8'h00, 31, 127);
      issue(OP_UNUSED, 8'hFF, 31, 127);
   endtask

   task automatic test_print_and_read();
      issue(OP_PUT, 8'h00, 31, 127);
      issue(OP_PUT, 8'hFF);
      issue(OP_PUT, 8'h41);
      issue(OP_READ, 8'h00, 0, 0);
      issue(OP_READ, 8'h00, 0, 1);
   endtask

   task automatic test_control_codes();
      issue(OP_PUT, CH_RETURN);
      issue(OP_PUT, CH_BACKSPACE);
      issue(OP_PUT, CH_NEWLINE);
      issue(OP_PUT, CH_BACKSPACE);
      issue(OP_READ, 8'h00, 0, SCREEN_WIDTH - 1);
      issue(OP_READ, 8'h00, 0, 0);
   endtask

   task automatic test_scroll();
      issue(OP_CLEAR, 8'h00);
      issue(OP_PUT, 8'h58);
      repeat (SCREEN_HEIGHT) issue(OP_PUT, CH_NEWLINE);
      issue(OP_READ, 8'h00, 0, 0);
      issue(OP_READ, 8'h00, SCREEN_HEIGHT - 1, 0);
   endtask

   task automatic test_colour_register();
      write_colour(8'hFF);
      issue(OP_CLEAR, 8'h00);
      issue(OP_READ, 8'h00, 10, 10);
      issue(OP_PUT, 8'h5A);
      write_colour(8'h00);
      issue(OP_PUT, CH_BACKSPACE);
      issue(OP_READ, 8'h00, 0, 0);
      issue(OP_READ, 8'h00, 1, 1);
   endtask

   initial begin
      for (int i = 0; i < CELL_COUNT; i++) begin
         shadow_cells[ADDR_W'(i)] = CELL_RESET;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait_idle();

      test_reset_state();
      test_print_and_read();
      test_control_codes();
      test_scroll();
      test_colour_register();

      write_colour(8'($urandom));
      test_random_traffic(400, 1'b1);
      write_colour(8'hFF);
      test_random_traffic(400, 1'b1);
      write_colour(COLOUR_RESET);
      test_random_traffic(400, 1'b1);
      write_colour(8'($urandom));
      test_random_traffic(450, 1'b0);

      wait_idle();
      repeat (CELL_COUNT + 16) @(posedge clock);
      if (mismatch_count == 0 && expected_rsps.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #150_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
